[hw/rtl/servo_channel_commander_top_defines.svh]
// Assertion macros for the servo channel commander.
// Included by the top level; no other dependencies.
`ifndef SERVO_CHANNEL_COMMANDER_TOP_DEFINES_SVH
`define SERVO_CHANNEL_COMMANDER_TOP_DEFINES_SVH
`ifndef SYNTH
// clocked check, masked while reset is asserted
`define SCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scc assertion failed");
// clocked check, also active during reset
`define SCC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("scc assertion failed");
`else
`define SCC_ASSERT(lbl, clk, rst_n, prop)
`define SCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hw/rtl/scc_pkg.sv]
// Shared types and constants for the servo channel commander.
// No dependencies.
package scc_pkg;

    // pulse timing in microseconds
    localparam logic [11:0] PULSE_MIN  = 12'd500;
    localparam logic [11:0] PULSE_MAX  = 12'd2500;
    localparam logic [11:0] PULSE_STOP = 12'd1500;
    localparam logic [11:0] PULSE_FWD  = 12'd1700;
    localparam logic [11:0] PULSE_BWD  = 12'd1300;

    // angle limits
    localparam logic [8:0] MAX_WIDE    = 9'd360;
    localparam logic [8:0] MAX_NARROW  = 9'd180;
    localparam logic [8:0] ANGLE4_BOOT = 9'd160;
    localparam int         BOOT4_INT   = 500 + (160 * 2000) / 180;
    localparam logic [11:0] PULSE4_BOOT = 12'(BOOT4_INT);

    // configuration reset values
    localparam logic [7:0]  COARSE_RESET = 8'd10;
    localparam logic [7:0]  FINE_RESET   = 8'd1;
    localparam logic [11:0] BOOT_RESET   = 12'd0;

    // configuration register indexes
    localparam logic [1:0] CFG_COARSE = 2'd0;
    localparam logic [1:0] CFG_FINE   = 2'd1;
    localparam logic [1:0] CFG_BOOT   = 2'd2;

    // action codes
    localparam logic [3:0] ACT_SET   = 4'd0;
    localparam logic [3:0] ACT_ADD   = 4'd1;
    localparam logic [3:0] ACT_SUB   = 4'd2;
    localparam logic [3:0] ACT_FWD   = 4'd3;
    localparam logic [3:0] ACT_BWD   = 4'd4;
    localparam logic [3:0] ACT_STOP  = 4'd5;
    localparam logic [3:0] ACT_PLEFT = 4'd6;
    localparam logic [3:0] ACT_PRGHT = 4'd7;
    localparam logic [3:0] ACT_PSTOP = 4'd8;
    localparam logic [3:0] ACT_TICK  = 4'd9;

    // servo ids
    localparam logic [2:0] SERVO_1 = 3'd1;
    localparam logic [2:0] SERVO_2 = 3'd2;
    localparam logic [2:0] SERVO_3 = 3'd3;
    localparam logic [2:0] SERVO_4 = 3'd4;

    typedef struct packed {
        logic [7:0]  time_ms;
        logic [15:0] angle;
        logic [2:0]  servo_num;
        logic [3:0]  action;
    } t_item;

    typedef struct packed {
        logic        drive_en_ch3;
        logic        drive_en_ch2;
        logic [11:0] pulse_ch5;
        logic [11:0] pulse_ch4;
        logic [11:0] pulse_ch3;
        logic [11:0] pulse_ch2;
        logic [11:0] pulse_ch1;
    } t_snapshot;

    typedef struct packed {
        logic [2:0] armed;
        logic [1:0] enable;
        logic [1:0] known;
    } t_status;

endpackage

[hw/rtl/scc_in_reg.sv]
// Input register stage of the servo channel commander.
// Depends on scc_pkg.
module scc_in_reg
    import scc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // action[3:0] servo_num[6:4] angle[22:7] time_ms[30:23]
    input  logic        i_advance,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    logic  s_fire;

    // free when empty or when the held item moves on this cycle
    assign s_axis_tready = !r_valid || i_advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_fire) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload unpack
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_item.action    <= s_axis_tdata[3:0];
            r_item.servo_num <= s_axis_tdata[6:4];
            r_item.angle     <= s_axis_tdata[22:7];
            r_item.time_ms   <= s_axis_tdata[30:23];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hw/rtl/scc_core.sv]
// Servo state registers and per-command update logic.
// Depends on scc_pkg.
module scc_core
    import scc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    output t_snapshot   o_next,
    output t_status     o_status
);

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;
    localparam logic [1:0] OP_SUB  = 2'd3;

    // 2000/max (50/9 or 100/9) folded with a 2^19 reciprocal of 9
    localparam logic [22:0] K_WIDE   = 23'd2912750;
    localparam logic [22:0] K_NARROW = 23'd5825500;
    // 180/2000 with a 2^19 reciprocal of 100
    localparam logic [15:0] K_BACK   = 16'd47187;

    logic [7:0]  r_coarse, n_coarse;
    logic [7:0]  r_fine,   n_fine;
    logic [11:0] r_boot,   n_boot;
    logic [11:0] r_pulse   [5];
    logic [11:0] n_pulse   [5];
    logic [8:0]  r_angle   [4];
    logic [8:0]  n_angle   [4];
    logic [1:0]  r_known,   n_known;
    logic [1:0]  r_enable,  n_enable;
    logic [1:0]  r_written, n_written;
    logic [2:0]  r_armed,   n_armed;
    logic [7:0]  r_remain  [3];
    logic [7:0]  n_remain  [3];

    logic [1:0]  op;
    logic [1:0]  op_idx;
    logic [7:0]  op_step;
    logic        id_valid;
    logic        is_linked;
    logic        lk;
    logic [1:0]  id_idx;

    logic [8:0]  cur_a;
    logic [8:0]  max_a;
    logic [9:0]  sum_a;
    logic [8:0]  a_new;
    logic [31:0] a_prod;
    logic [11:0] p_new;
    logic [11:0] rb_p;
    logic [10:0] rb_y;
    logic [26:0] rb_prod;
    logic [8:0]  rb_angle;

    assign id_valid  = (i_item.servo_num >= SERVO_1) && (i_item.servo_num <= SERVO_4);
    assign is_linked = (i_item.servo_num == SERVO_2) || (i_item.servo_num == SERVO_3);
    assign lk        = i_item.servo_num[0];
    assign id_idx    = 2'(i_item.servo_num - 3'd1);

    // angle operation decode
    always_comb begin
        op      = OP_NONE;
        op_idx  = id_idx;
        op_step = r_coarse;
        unique case (i_item.action) inside
            ACT_SET: if (id_valid) op = OP_SET;
            ACT_ADD: if (id_valid) op = OP_ADD;
            ACT_SUB: if (id_valid) op = OP_SUB;
            ACT_FWD, ACT_BWD: begin
                if (is_linked) begin
                    if (r_known[lk]) begin
                        op = (i_item.action == ACT_FWD) ? OP_ADD : OP_SUB;
                    end
                end else if (i_item.servo_num != SERVO_1) begin
                    op      = (i_item.action == ACT_FWD) ? OP_ADD : OP_SUB;
                    op_idx  = 2'd3;
                    op_step = r_fine;
                end
            end
            ACT_STOP: begin
                // stop of servo four rewrites its pulse from its angle
                if (i_item.servo_num == SERVO_4) begin
                    op      = OP_ADD;
                    op_step = 8'd0;
                end
            end
            default: op = OP_NONE;
        endcase
    end

    // angle update with clamping, then angle to pulse
    assign cur_a = r_angle[op_idx];
    assign max_a = (op_idx == 2'd0) ? MAX_WIDE : MAX_NARROW;
    assign sum_a = {1'b0, cur_a} + {2'b0, op_step};

    always_comb begin
        case (op)
            OP_SET:  a_new = (i_item.angle > {7'b0, max_a}) ? max_a : i_item.angle[8:0];
            OP_ADD:  a_new = (sum_a > {1'b0, max_a}) ? max_a : sum_a[8:0];
            OP_SUB:  a_new = (cur_a < {1'b0, op_step}) ? 9'd0 : cur_a - {1'b0, op_step};
            default: a_new = cur_a;
        endcase
    end

    assign a_prod = {23'b0, a_new} * {9'b0, (op_idx == 2'd0) ? K_WIDE : K_NARROW};
    assign p_new  = PULSE_MIN + {1'b0, a_prod[29:19]};

    // read back a linked servo's angle from its pulse
    always_comb begin
        rb_p = r_pulse[{1'b0, id_idx}];
        if (rb_p < PULSE_MIN) begin
            rb_p = PULSE_MIN;
        end else if (rb_p > PULSE_MAX) begin
            rb_p = PULSE_MAX;
        end
    end
    assign rb_y     = 11'(rb_p - PULSE_MIN);
    assign rb_prod  = {16'b0, rb_y} * {11'b0, K_BACK};
    assign rb_angle = {1'b0, rb_prod[26:19]};

    // next state
    always_comb begin
        n_coarse  = r_coarse;
        n_fine    = r_fine;
        n_boot    = r_boot;
        n_pulse   = r_pulse;
        n_angle   = r_angle;
        n_known   = r_known;
        n_enable  = r_enable;
        n_written = r_written;
        n_armed   = r_armed;
        n_remain  = r_remain;

        if (i_fire) begin
            unique case (i_item.action) inside
                ACT_FWD, ACT_BWD: begin
                    if (i_item.servo_num == SERVO_1) begin
                        n_pulse[0]  = (i_item.action == ACT_FWD) ? PULSE_FWD : PULSE_BWD;
                        n_armed[0]  = 1'b1;
                        n_remain[0] = i_item.time_ms;
                    end else if (is_linked) begin
                        if (!r_known[lk]) begin
                            n_angle[id_idx] = rb_angle;
                            n_known[lk]     = 1'b1;
                        end else begin
                            n_enable[lk]        = 1'b1;
                            n_armed[id_idx]     = 1'b1;
                            n_remain[id_idx]    = i_item.time_ms;
                        end
                    end
                end
                ACT_STOP: begin
                    if (i_item.servo_num == SERVO_1) begin
                        n_pulse[0]  = PULSE_STOP;
                        n_armed[0]  = 1'b0;
                        n_remain[0] = 8'd0;
                    end else if (is_linked) begin
                        n_enable[lk]     = 1'b0;
                        n_armed[id_idx]  = 1'b0;
                        n_remain[id_idx] = 8'd0;
                    end
                end
                ACT_PLEFT: n_pulse[4] = PULSE_FWD;
                ACT_PRGHT: n_pulse[4] = PULSE_BWD;
                ACT_PSTOP: n_pulse[4] = PULSE_STOP;
                ACT_TICK: begin
                    // armed stops count down and fire at one or zero
                    for (int k = 0; k < 3; k++) begin
                        if (r_armed[k]) begin
                            if (r_remain[k] <= 8'd1) begin
                                n_armed[k]  = 1'b0;
                                n_remain[k] = 8'd0;
                                if (k == 0) begin
                                    n_pulse[0] = PULSE_STOP;
                                end else begin
                                    n_enable[1'(k - 1)] = 1'b0;
                                end
                            end else begin
                                n_remain[k] = r_remain[k] - 8'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (op != OP_NONE) begin
                n_angle[op_idx]           = a_new;
                n_pulse[{1'b0, op_idx}]   = p_new;
                if (op_idx == 2'd1) n_written[0] = 1'b1;
                if (op_idx == 2'd2) n_written[1] = 1'b1;
            end
        end

        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COARSE: n_coarse = i_cfg_data[7:0];
                CFG_FINE:   n_fine   = i_cfg_data[7:0];
                CFG_BOOT: begin
                    n_boot = i_cfg_data;
                    if (!r_written[0]) n_pulse[1] = i_cfg_data;
                    if (!r_written[1]) n_pulse[2] = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse  <= COARSE_RESET;
            r_fine    <= FINE_RESET;
            r_boot    <= BOOT_RESET;
            r_pulse   <= '{PULSE_STOP, BOOT_RESET, BOOT_RESET, PULSE4_BOOT, PULSE_STOP};
            r_angle   <= '{9'd0, 9'd0, 9'd0, ANGLE4_BOOT};
            r_known   <= 2'b00;
            r_enable  <= 2'b00;
            r_written <= 2'b00;
            r_armed   <= 3'b000;
            r_remain  <= '{8'd0, 8'd0, 8'd0};
        end else begin
            r_coarse  <= n_coarse;
            r_fine    <= n_fine;
            r_boot    <= n_boot;
            r_pulse   <= n_pulse;
            r_angle   <= n_angle;
            r_known   <= n_known;
            r_enable  <= n_enable;
            r_written <= n_written;
            r_armed   <= n_armed;
            r_remain  <= n_remain;
        end
    end

    // post-update snapshot for the result register
    assign o_next.pulse_ch1    = n_pulse[0];
    assign o_next.pulse_ch2    = n_pulse[1];
    assign o_next.pulse_ch3    = n_pulse[2];
    assign o_next.pulse_ch4    = n_pulse[3];
    assign o_next.pulse_ch5    = n_pulse[4];
    assign o_next.drive_en_ch2 = n_enable[0];
    assign o_next.drive_en_ch3 = n_enable[1];

    assign o_status.armed  = r_armed;
    assign o_status.enable = r_enable;
    assign o_status.known  = r_known;

endmodule

[hw/rtl/servo_channel_commander_top.sv]
// Top level of the servo channel commander: input stage, core, result register.
// Depends on scc_pkg, scc_in_reg, scc_core and the assertion macro header.
//
// Usage:
//   Commands enter on the s_axis channel, one item per handshake. Each item
//   yields one result on m_axis: all five compare pulses and the drive
//   enables of servos two and three, sampled after that command took effect.
//   The item moves from the input register through the update logic into
//   the result register, which drives m_axis_tvalid. One item is accepted
//   every cycle while results are taken, as the input register feeds the update
//   logic (one constant multiply for angle to pulse) into the result register.
//   Configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while no item is in flight; index 3 is ignored.
//   Reset (synchronous, active low) loads pulses 1500, boot, boot, 2277,
//   1500, servo four angle 160, and clears enables, flags and timers.
//   When m_axis_tready is low the result holds; one more item may enter the
//   input register, after which s_axis_tready drops until the result is taken.
`include "servo_channel_commander_top_defines.svh"
module servo_channel_commander_top
    import scc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // action[3:0] servo_num[6:4] angle[22:7] time_ms[30:23]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // pulse_ch1..ch5 [59:0] 12b each, drive_en_ch2[60], drive_en_ch3[61]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data
);

    logic      in_valid;
    t_item     in_item;
    logic      advance;
    t_snapshot next_snap;
    t_status   status;
    logic      r_out_valid;
    t_snapshot r_out;

    // the held item moves into the result register when that is free
    assign advance = in_valid && (!r_out_valid || m_axis_tready);

    scc_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_advance     (advance),
        .o_valid       (in_valid),
        .o_item        (in_item)
    );

    scc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_item     (in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_next     (next_snap),
        .o_status   (status)
    );

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_snap;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.drive_en_ch3, r_out.drive_en_ch2,
                            r_out.pulse_ch5, r_out.pulse_ch4, r_out.pulse_ch3,
                            r_out.pulse_ch2, r_out.pulse_ch1};

    // a linked drive only runs with its stop timer armed and position learned
    `SCC_ASSERT(a_en2_armed, i_clk, i_rst_n, !status.enable[0] || (status.armed[1] && status.known[0]))
    `SCC_ASSERT(a_en3_armed, i_clk, i_rst_n, !status.enable[1] || (status.armed[2] && status.known[1]))
    // input side stalls only with an item held
    `SCC_ASSERT(a_stall_full, i_clk, i_rst_n, s_axis_tready || in_valid)
    // a new result comes only from a held item
    `SCC_ASSERT(a_out_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(in_valid))

endmodule

[tb/tb.sv]
// Self-checking testbench for servo_channel_commander_top:
// commands in on s_axis, snapshots out on m_axis.
// Depends on scc_pkg and the RTL of the commander; the snapshot predictor lives in the class below.
module tb;
    import scc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] ACT_SPARE_LO  = 4'd10;
    localparam logic [3:0] ACT_SPARE_HI  = 4'd15;
    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam logic [2:0] SERVO_NONE    = 3'd0;
    localparam logic [2:0] SERVO_TOP     = 3'd7;
    localparam logic [2:0] SERVO_5       = 3'd5;
    localparam int WATCHDOG_LIMIT        = 2000;
    localparam int PHASE_ITEMS           = 196;

    // predicts the pulse/enable snapshot for every accepted command
    class snapshot_scoreboard;
        logic [7:0]  coarse_step;
        logic [7:0]  fine_step;
        logic [11:0] boot_pulse;
        logic [11:0] pulse [5];
        logic [8:0]  angle [4];
        bit          known [2];
        bit          enable [2];
        bit          written [2];
        bit          armed [3];
        logic [7:0]  remaining [3];
        t_snapshot   pending_snapshots [$];
        int          errors;
        string       field_names [7] = '{"pulse_ch1", "pulse_ch2", "pulse_ch3", "pulse_ch4",
                                         "pulse_ch5", "drive_en_ch2", "drive_en_ch3"};

        function new();
            coarse_step = COARSE_RESET;
            fine_step   = FINE_RESET;
            boot_pulse  = BOOT_RESET;
            pulse[0]    = PULSE_STOP;
            pulse[1]    = BOOT_RESET;
            pulse[2]    = BOOT_RESET;
            pulse[4]    = PULSE_STOP;
            foreach (angle[i]) angle[i] = '0;
            foreach (known[i]) begin
                known[i]   = 1'b0;
                enable[i]  = 1'b0;
                written[i] = 1'b0;
            end
            foreach (armed[i]) begin
                armed[i]     = 1'b0;
                remaining[i] = '0;
            end
            errors = 0;
            set_angle(4, int'(ANGLE4_BOOT));
        endfunction

        function int servo_max(int id);
            return (id == 1) ? int'(MAX_WIDE) : int'(MAX_NARROW);
        endfunction

        function void write_pulse(int id, int p);
            pulse[id-1] = p[11:0];
            if (id == 2 || id == 3) begin
                written[id-2] = 1'b1;
            end
        endfunction

        // clamp to the servo range, then angle -> compare pulse
        function void set_angle(int id, int a);
            int m;
            m = servo_max(id);
            if (a > m) a = m;
            angle[id-1] = a[8:0];
            write_pulse(id, int'(PULSE_MIN) + a * (int'(PULSE_MAX) - int'(PULSE_MIN)) / m);
        endfunction

        // saturating relative move
        function void step_angle(int id, int step, bit up);
            int m;
            int a;
            m = servo_max(id);
            a = int'(angle[id-1]);
            if (up) begin
                set_angle(id, (a + step > m) ? m : a + step);
            end else begin
                set_angle(id, (a < step) ? 0 : a - step);
            end
        endfunction

        function void arm_stop(int k, logic [7:0] ms);
            armed[k]     = 1'b1;
            remaining[k] = ms;
        endfunction

        function void turn(int id, logic [7:0] ms, bit up);
            int k;
            int p;
            if (id == 1) begin
                write_pulse(1, up ? int'(PULSE_FWD) : int'(PULSE_BWD));
                arm_stop(0, ms);
            end else if (id == 2 || id == 3) begin
                k = id - 2;
                // first turn of a linked servo only learns its angle from the pulse
                if (!known[k]) begin
                    p = int'(pulse[id-1]);
                    if (p < int'(PULSE_MIN)) p = int'(PULSE_MIN);
                    if (p > int'(PULSE_MAX)) p = int'(PULSE_MAX);
                    angle[id-1] = 9'((p - int'(PULSE_MIN)) * int'(MAX_NARROW)
                                     / (int'(PULSE_MAX) - int'(PULSE_MIN)));
                    known[k] = 1'b1;
                    return;
                end
                step_angle(id, int'(coarse_step), up);
                enable[k] = 1'b1;
                arm_stop(id - 1, ms);
            end else begin
                step_angle(4, int'(fine_step), up);
            end
        endfunction

        function void halt_servo(int id);
            if (id == 1) begin
                write_pulse(1, int'(PULSE_STOP));
                armed[0]     = 1'b0;
                remaining[0] = '0;
            end else if (id == 2 || id == 3) begin
                enable[id-2]    = 1'b0;
                armed[id-1]     = 1'b0;
                remaining[id-1] = '0;
            end else if (id == 4) begin
                set_angle(4, int'(angle[3]));
            end
        endfunction

        // millisecond tick: fire or count down every armed stop
        function void tick();
            for (int k = 0; k < 3; k++) begin
                if (armed[k]) begin
                    if (remaining[k] <= 8'd1) begin
                        armed[k]     = 1'b0;
                        remaining[k] = '0;
                        if (k == 0) write_pulse(1, int'(PULSE_STOP));
                        else enable[k-1] = 1'b0;
                    end else begin
                        remaining[k] = remaining[k] - 8'd1;
                    end
                end
            end
        endfunction

        function void write_register(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_COARSE: coarse_step = data[7:0];
                CFG_FINE:   fine_step   = data[7:0];
                CFG_BOOT: begin
                    boot_pulse = data;
                    if (!written[0]) pulse[1] = data;
                    if (!written[1]) pulse[2] = data;
                end
                default: ;
            endcase
        endfunction

        // note an accepted command and queue the snapshot it must produce
        function void apply_command(t_item c);
            int id;
            bit in_range;
            t_snapshot s;
            id = int'(c.servo_num);
            in_range = (id >= 1 && id <= 4);
            case (c.action)
                ACT_SET:   if (in_range) set_angle(id, int'(c.angle));
                ACT_ADD:   if (in_range) step_angle(id, int'(coarse_step), 1'b1);
                ACT_SUB:   if (in_range) step_angle(id, int'(coarse_step), 1'b0);
                ACT_FWD:   turn(id, c.time_ms, 1'b1);
                ACT_BWD:   turn(id, c.time_ms, 1'b0);
                ACT_STOP:  halt_servo(id);
                ACT_PLEFT: pulse[4] = PULSE_FWD;
                ACT_PRGHT: pulse[4] = PULSE_BWD;
                ACT_PSTOP: pulse[4] = PULSE_STOP;
                ACT_TICK:  tick();
                default: ;
            endcase
            s.pulse_ch1    = pulse[0];
            s.pulse_ch2    = pulse[1];
            s.pulse_ch3    = pulse[2];
            s.pulse_ch4    = pulse[3];
            s.pulse_ch5    = pulse[4];
            s.drive_en_ch2 = enable[0];
            s.drive_en_ch3 = enable[1];
            pending_snapshots.push_back(s);
        endfunction

        function void check_snapshot(logic [63:0] raw);
            t_snapshot got;
            t_snapshot want;
            int exp_vals [7];
            int act_vals [7];
            got = raw[61:0];
            if (pending_snapshots.size() == 0) begin
                $display("%0t: unexpected result %h", $time, raw);
                errors++;
                return;
            end
            want = pending_snapshots.pop_front();
            exp_vals = '{want.pulse_ch1, want.pulse_ch2, want.pulse_ch3, want.pulse_ch4,
                         want.pulse_ch5, want.drive_en_ch2, want.drive_en_ch3};
            act_vals = '{got.pulse_ch1, got.pulse_ch2, got.pulse_ch3, got.pulse_ch4,
                         got.pulse_ch5, got.drive_en_ch2, got.drive_en_ch3};
            foreach (exp_vals[i]) begin
                if (exp_vals[i] !== act_vals[i]) begin
                    $display("%0t: %s expected %0d actual %0d", $time, field_names[i],
                             exp_vals[i], act_vals[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = '0;
    logic [11:0] i_cfg_data    = '0;

    snapshot_scoreboard board;
    int tx_idle_pct  = 22;
    int rx_idle_pct  = 63;
    int quiet_cycles = 0;
    t_item directed_cmds [$];

    servo_channel_commander_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side: random back-pressure, check every accepted snapshot
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) board.check_snapshot(m_axis_tdata);
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic t_item make_command(logic [3:0] act, logic [2:0] id,
                                           logic [15:0] ang, logic [7:0] ms);
        t_item c;
        c.action    = act;
        c.servo_num = id;
        c.angle     = ang;
        c.time_ms   = ms;
        return c;
    endfunction

    // mostly turns and ticks with short timers so the automatic stops fire
    function automatic t_item random_command();
        t_item c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)      c.action = ACT_SET;
        else if (r < 18) c.action = ACT_ADD;
        else if (r < 26) c.action = ACT_SUB;
        else if (r < 40) c.action = ACT_FWD;
        else if (r < 52) c.action = ACT_BWD;
        else if (r < 60) c.action = ACT_STOP;
        else if (r < 64) c.action = ACT_PLEFT;
        else if (r < 67) c.action = ACT_PRGHT;
        else if (r < 70) c.action = ACT_PSTOP;
        else if (r < 95) c.action = ACT_TICK;
        else             c.action = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        if ($urandom_range(0, 99) < 80) c.servo_num = 3'($urandom_range(SERVO_1, SERVO_4));
        else                            c.servo_num = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 70) c.angle = 16'($urandom_range(0, 400));
        else                            c.angle = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 70) c.time_ms = 8'($urandom_range(0, 6));
        else                            c.time_ms = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // offer one item, with random idle cycles first; valid stays up afterwards
    task automatic push_command(input t_item c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, c};
        do @(posedge i_clk); while (!s_axis_tready);
        board.apply_command(c);
    endtask

    // drop valid and wait until every snapshot has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_snapshots.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [11:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.write_register(idx, data);
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset configuration: learn servo two from a zero boot pulse
        directed_cmds.push_back(make_command(ACT_PLEFT, SERVO_TOP, 16'hFFFF, 8'hFF));
        directed_cmds.push_back(make_command(ACT_FWD, SERVO_2, 16'h0000, 8'd0));
        directed_cmds.push_back(make_command(ACT_FWD, SERVO_2, 16'h0000, 8'd0));
        directed_cmds.push_back(make_command(ACT_TICK, SERVO_NONE, 16'h0000, 8'd0));
        foreach (directed_cmds[i]) push_command(directed_cmds[i]);
        drain();

        // boot pulse lands only on the still-unwritten channel three
        write_register(CFG_BOOT, PULSE_MAX);
        write_register(CFG_COARSE, 12'd180);
        write_register(CFG_FINE, 12'd180);
        write_register(CFG_SPARE, 12'hFFF);

        directed_cmds.delete();
        directed_cmds.push_back(make_command(ACT_BWD, SERVO_3, 16'd0, 8'd1));
        directed_cmds.push_back(make_command(ACT_BWD, SERVO_3, 16'd0, 8'd3));
        directed_cmds.push_back(make_command(ACT_FWD, SERVO_1, 16'd0, 8'd2));
        directed_cmds.push_back(make_command(ACT_TICK, SERVO_1, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_TICK, SERVO_TOP, 16'hFFFF, 8'hFF));
        directed_cmds.push_back(make_command(ACT_STOP, SERVO_3, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_SET, SERVO_1, 16'hFFFF, 8'd0));
        directed_cmds.push_back(make_command(ACT_SET, SERVO_4, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_BWD, SERVO_NONE, 16'd0, 8'd9));
        directed_cmds.push_back(make_command(ACT_FWD, SERVO_TOP, 16'd0, 8'd9));
        directed_cmds.push_back(make_command(ACT_ADD, SERVO_1, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_SUB, SERVO_2, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_SET, SERVO_5, 16'd100, 8'd0));
        directed_cmds.push_back(make_command(ACT_STOP, SERVO_4, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_STOP, SERVO_1, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_STOP, SERVO_NONE, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_PRGHT, SERVO_1, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_PSTOP, SERVO_1, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_SPARE_HI, SERVO_4, 16'hFFFF, 8'hFF));
        directed_cmds.push_back(make_command(ACT_SPARE_LO, SERVO_1, 16'd0, 8'd0));
        directed_cmds.push_back(make_command(ACT_SET, SERVO_2, 16'd180, 8'd0));
        foreach (directed_cmds[i]) push_command(directed_cmds[i]);
        drain();

        // random phases; idling changes every two phases, settings every phase
        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                tx_idle_pct = 22;
                rx_idle_pct = 63;
            end else if (phase < 4) begin
                tx_idle_pct = 63;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase)
                0: begin
                    write_register(CFG_COARSE, 12'd0);
                    write_register(CFG_FINE, 12'd180);
                    write_register(CFG_BOOT, 12'd0);
                end
                1: begin
                    write_register(CFG_COARSE, 12'd180);
                    write_register(CFG_FINE, 12'd0);
                    write_register(CFG_BOOT, PULSE_MAX);
                end
                default: begin
                    write_register(CFG_COARSE, 12'($urandom_range(0, 180)));
                    write_register(CFG_FINE, 12'($urandom_range(0, 180)));
                    write_register(CFG_BOOT, 12'($urandom_range(0, 2500)));
                end
            endcase
            repeat (PHASE_ITEMS) push_command(random_command());
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending_snapshots.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
